FILE: sv/dts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg - shared types and constants
// Item and result layouts, access kinds and register addresses for the
// divider, timer and serial port register block.
// ----------------------------------------------------------------------------
package dts_pkg;

  // Access kinds carried by an input item (code 3 behaves as idle)
  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } access_kind_t;

  // Register addresses (low address bits)
  localparam logic [2:0] ADDR_SDATA   = 3'd1;
  localparam logic [2:0] ADDR_SCTRL   = 3'd2;
  localparam logic [2:0] ADDR_DIVIDER = 3'd4;
  localparam logic [2:0] ADDR_TCOUNT  = 3'd5;
  localparam logic [2:0] ADDR_TRELOAD = 3'd6;
  localparam logic [2:0] ADDR_TCTRL   = 3'd7;

  localparam int DIV_W       = 14;
  localparam int ITEM_BITS   = 13;
  localparam int IN_TDATA_W  = 16;
  localparam int RES_BITS    = 10;
  localparam int OUT_TDATA_W = 16;

  // Input item, first field in the highest bits
  typedef struct packed {
    logic [7:0] write_data;
    logic [2:0] reg_addr;
    logic [1:0] access_kind;
  } item_t;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic       serial_irq;
    logic       timer_irq;
    logic [7:0] read_data;
  } result_t;

endpackage

FILE: sv/divider_timer_serial_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divider_timer_serial_regs - divider, timer and serial port registers
// Channel  Dir  Accepted when             Payload
// in_      in   in_tvalid & in_tready     tdata: kind, addr, write byte
// out_     out  out_tvalid & out_tready   tdata: read byte, timer irq, serial irq
// One item per clock sustained while the output is not stalled; an item
// passes through the input register, then the result register.
// The state advances as an item leaves the input register, one machine cycle
// per item. Reset (synchronous, rst_n low) clears all state and both stages.
// A stalled output holds the result; an empty input register still takes an item.
// ----------------------------------------------------------------------------
module divider_timer_serial_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [1:0] access_kind, [4:2] reg_addr, [12:5] write_data, [15:13] zero
  input  logic [dts_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] read_data, [8] timer_irq, [9] serial_irq, [15:10] zero
  output logic [dts_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dts_pkg::*;

  item_t   item_r;
  logic    item_vld_r;
  result_t res_r;
  result_t res;
  logic    out_vld_r;
  logic    step;

  // Item moves on when the result register is free or being emptied
  assign step      = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || step;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata[ITEM_BITS-1:0]);
    end
  end

  dts_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-RES_BITS){1'b0}}, res_r};

endmodule

FILE: sv/dts_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_core - machine cycle state and register file
// Holds the divider, timer and serial state. On each step it advances one
// machine cycle, then applies the item's register access; the result is
// combinational from the current state and item.
// ----------------------------------------------------------------------------
module dts_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  dts_pkg::item_t  item,
  output dts_pkg::result_t res
);
  import dts_pkg::*;

  logic [DIV_W-1:0] div_r,   div_nxt;
  logic [7:0]       tcnt_r,  tcnt_nxt;
  logic [7:0]       trld_r,  trld_nxt;
  logic [2:0]       tctl_r,  tctl_nxt;
  logic             tlvl_r,  tlvl_nxt;
  logic [7:0]       sdat_r,  sdat_nxt;
  logic             sstart_r, sstart_nxt;  // serial control bit 7
  logic             sclk_r,   sclk_nxt;    // serial control bit 0
  logic [3:0]       sleft_r, sleft_nxt;

  // Cycle results before the register access
  logic [DIV_W-1:0] div_cyc;
  logic [7:0]       tcnt_cyc, sdat_cyc, tcnt_inc;
  logic             sstart_cyc, lvl, tirq, sirq, shift_en;
  logic [3:0]       sleft_cyc;
  logic [7:0]       rdata;

  // Divider bit chosen by the timer control selector
  function automatic logic clock_select(input logic [2:0] ctl, input logic [DIV_W-1:0] dv);
    logic sel;
    unique case (ctl)
      3'd4:    sel = dv[7];
      3'd5:    sel = dv[1];
      3'd6:    sel = dv[3];
      3'd7:    sel = dv[5];
      default: sel = 1'b0;
    endcase
    return sel;
  endfunction

  // One machine cycle: serial shift, divider, timer
  always_comb begin
    shift_en   = (div_r[6:0] == 7'd0) && (sleft_r != 4'd0) && sstart_r && sclk_r;
    sdat_cyc   = shift_en ? {sdat_r[6:0], 1'b1} : sdat_r;
    sleft_cyc  = shift_en ? sleft_r - 4'd1 : sleft_r;
    sirq       = shift_en && (sleft_r == 4'd1);
    sstart_cyc = sstart_r && !sirq;

    div_cyc  = div_r + {{(DIV_W-1){1'b0}}, 1'b1};
    lvl      = clock_select(tctl_r, div_cyc);
    tcnt_inc = tcnt_r + 8'd1;
    tirq     = tlvl_r && !lvl && (tcnt_inc == 8'd0);
    if (tlvl_r && !lvl) begin
      tcnt_cyc = tirq ? trld_r : tcnt_inc;
    end else begin
      tcnt_cyc = tcnt_r;
    end
  end

  // Register read sees the state after the cycle
  always_comb begin
    unique case (item.reg_addr)
      ADDR_SDATA:   rdata = sdat_cyc;
      ADDR_SCTRL:   rdata = {sstart_cyc, 6'h3f, sclk_r};
      ADDR_DIVIDER: rdata = div_cyc[DIV_W-1:DIV_W-8];
      ADDR_TCOUNT:  rdata = tcnt_cyc;
      ADDR_TRELOAD: rdata = trld_r;
      ADDR_TCTRL:   rdata = {5'h1f, tctl_r};
      default:      rdata = 8'hff;
    endcase
  end

  // Next state: cycle result, then a write access on top
  always_comb begin
    div_nxt    = div_cyc;
    tcnt_nxt   = tcnt_cyc;
    trld_nxt   = trld_r;
    tctl_nxt   = tctl_r;
    tlvl_nxt   = lvl;
    sdat_nxt   = sdat_cyc;
    sstart_nxt = sstart_cyc;
    sclk_nxt   = sclk_r;
    sleft_nxt  = sleft_cyc;
    if (item.access_kind == KIND_WRITE) begin
      unique case (item.reg_addr)
        ADDR_SDATA:   sdat_nxt = item.write_data;
        ADDR_SCTRL: begin
          sstart_nxt = item.write_data[7];
          sclk_nxt   = item.write_data[0];
          if (item.write_data[7] && item.write_data[0]) begin
            sleft_nxt = 4'd8;
          end
        end
        ADDR_DIVIDER: div_nxt  = '0;
        ADDR_TCOUNT:  tcnt_nxt = item.write_data;
        ADDR_TRELOAD: trld_nxt = item.write_data;
        ADDR_TCTRL:   tctl_nxt = item.write_data[2:0];
        default:      ;
      endcase
    end
  end

  assign res.read_data  = (item.access_kind == KIND_READ) ? rdata : 8'h00;
  assign res.timer_irq  = tirq;
  assign res.serial_irq = sirq;

  // State registers advance once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r    <= '0;
      tcnt_r   <= '0;
      trld_r   <= '0;
      tctl_r   <= '0;
      tlvl_r   <= 1'b0;
      sdat_r   <= '0;
      sstart_r <= 1'b0;
      sclk_r   <= 1'b0;
      sleft_r  <= '0;
    end else if (step) begin
      div_r    <= div_nxt;
      tcnt_r   <= tcnt_nxt;
      trld_r   <= trld_nxt;
      tctl_r   <= tctl_nxt;
      tlvl_r   <= tlvl_nxt;
      sdat_r   <= sdat_nxt;
      sstart_r <= sstart_nxt;
      sclk_r   <= sclk_nxt;
      sleft_r  <= sleft_nxt;
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - divider, timer and serial port register block testbench
// Feeds machine-cycle items, each optionally carrying a register access, into
// the stream input with random gaps, and takes results with random stalls.
// A cycle-accurate copy of the divider, timer and serial state predicts every
// result, which is checked field by field in order of arrival. Stimulus is a
// short directed run, an idle stretch with a serial transfer under way, then
// random timer and serial sequences mixed with noise.
// ----------------------------------------------------------------------------
module tb;
  import dts_pkg::*;

  // Codes not named in the package
  localparam logic [1:0] KIND_UNDEF   = 2'd3;
  localparam logic [2:0] ADDR_HOLE_LO = 3'd0;
  localparam logic [2:0] ADDR_HOLE_HI = 3'd3;
  // Timer clock selectors
  localparam logic [2:0] TSEL_OFF  = 3'd0;
  localparam logic [2:0] TSEL_BIT7 = 3'd4;
  localparam logic [2:0] TSEL_BIT1 = 3'd5;
  localparam logic [2:0] TSEL_BIT3 = 3'd6;
  localparam logic [2:0] TSEL_BIT5 = 3'd7;
  localparam logic [7:0] SCTRL_GO   = 8'h81;
  localparam logic [7:0] SCTRL_MASK = 8'h81;
  localparam int RANDOM_ITEMS = 1150;
  localparam int SOAK_ITEMS   = 200;
  localparam int DRAIN_CYCLES = 8;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  item_t   pending_q[$];
  result_t expected_q[$];
  int      fail_count = 0;

  // Predicted machine state
  logic [DIV_W-1:0] div_cnt;
  logic [7:0]       tmr_cnt;
  logic [7:0]       tmr_reload;
  logic [2:0]       tmr_ctrl;
  logic             tmr_clk_lvl;
  logic [7:0]       ser_data;
  logic [7:0]       ser_ctrl;
  logic [3:0]       ser_bits_left;

  divider_timer_serial_regs uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Divider bit that clocks the timer, low when the timer is off
  function automatic logic timer_tap(input logic [2:0] ctl, input logic [DIV_W-1:0] dv);
    case (ctl)
      TSEL_BIT7: return dv[7];
      TSEL_BIT1: return dv[1];
      TSEL_BIT3: return dv[3];
      TSEL_BIT5: return dv[5];
      default:   return 1'b0;
    endcase
  endfunction

  // Advance one machine cycle, then apply the access; returns the result
  function automatic result_t run_machine_cycle(input item_t it);
    result_t    res;
    logic       lvl;
    logic [7:0] rd;
    res = '0;
    rd  = 8'h00;

    // serial shift on divider low bits rolling over to zero
    if (div_cnt[6:0] == 7'd0 && ser_bits_left != 4'd0 && ser_ctrl == SCTRL_GO) begin
      ser_data      = {ser_data[6:0], 1'b1};
      ser_bits_left = ser_bits_left - 4'd1;
      if (ser_bits_left == 4'd0) begin
        ser_ctrl[7]    = 1'b0;
        res.serial_irq = 1'b1;
      end
    end

    div_cnt = div_cnt + {{(DIV_W-1){1'b0}}, 1'b1};

    // timer clocked on a falling edge of the tapped bit
    lvl = timer_tap(tmr_ctrl, div_cnt);
    if (tmr_clk_lvl && !lvl) begin
      tmr_cnt = tmr_cnt + 8'd1;
      if (tmr_cnt == 8'd0) begin
        tmr_cnt       = tmr_reload;
        res.timer_irq = 1'b1;
      end
    end
    tmr_clk_lvl = lvl;

    // register access sees the state after the cycle
    if (it.access_kind == KIND_READ) begin
      case (it.reg_addr)
        ADDR_SDATA:   rd = ser_data;
        ADDR_SCTRL:   rd = ser_ctrl | 8'h7e;
        ADDR_DIVIDER: rd = div_cnt[13:6];
        ADDR_TCOUNT:  rd = tmr_cnt;
        ADDR_TRELOAD: rd = tmr_reload;
        ADDR_TCTRL:   rd = {5'h1f, tmr_ctrl};
        default:      rd = 8'hff;
      endcase
    end else if (it.access_kind == KIND_WRITE) begin
      case (it.reg_addr)
        ADDR_SDATA: ser_data = it.write_data;
        ADDR_SCTRL: begin
          ser_ctrl = it.write_data & SCTRL_MASK;
          if (ser_ctrl == SCTRL_GO) ser_bits_left = 4'd8;
        end
        ADDR_DIVIDER: div_cnt = '0;
        ADDR_TCOUNT:  tmr_cnt = it.write_data;
        ADDR_TRELOAD: tmr_reload = it.write_data;
        ADDR_TCTRL:   tmr_ctrl = it.write_data[2:0];
        default: ;
      endcase
    end
    res.read_data = rd;
    return res;
  endfunction

  task automatic add_item(input logic [1:0] kind, input logic [2:0] addr,
                          input logic [7:0] data);
    item_t it;
    it.access_kind = kind;
    it.reg_addr    = addr;
    it.write_data  = data;
    pending_q.push_back(it);
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= 60)
      $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
  endtask

  // Input driver: random gap after each accepted item, with runs of no gaps
  int gap_left = 0;
  bit tx_burst = 1'b0;
  always @(posedge clk) begin
    logic  nxt_valid;
    item_t nxt_item;
    item_t taken;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      nxt_valid = in_tvalid;
      nxt_item  = item_t'(in_tdata[ITEM_BITS-1:0]);
      if (in_tvalid && in_tready) begin
        taken = item_t'(in_tdata[ITEM_BITS-1:0]);
        expected_q.push_back(run_machine_cycle(taken));
        nxt_valid = 1'b0;
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        gap_left = tx_burst ? 0 : $urandom_range(0, 8);
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          nxt_item  = pending_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
      in_tdata  <= {{(IN_TDATA_W-ITEM_BITS){1'b0}}, nxt_item};
    end
  end

  // Result monitor: random stall after each result, with runs of no stalls
  int stall_left = 0;
  bit rx_burst = 1'b0;
  always @(posedge clk) begin
    logic    nxt_ready;
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      nxt_ready = out_tready;
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[RES_BITS-1:0]);
        if (expected_q.size() == 0) begin
          note_mismatch("unexpected result", 0, got);
        end else begin
          want = expected_q.pop_front();
          if (got.read_data !== want.read_data)
            note_mismatch("read_data", want.read_data, got.read_data);
          if (got.timer_irq !== want.timer_irq)
            note_mismatch("timer_irq", want.timer_irq, got.timer_irq);
          if (got.serial_irq !== want.serial_irq)
            note_mismatch("serial_irq", want.serial_irq, got.serial_irq);
        end
        if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
        stall_left = rx_burst ? 0 : $urandom_range(0, 8);
        nxt_ready  = (stall_left == 0);
      end else if (!out_tready) begin
        if (stall_left > 0) stall_left--;
        if (stall_left == 0) nxt_ready = 1'b1;
      end
      out_tready <= nxt_ready;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int n_random;
    int len;
    int pick;
    div_cnt       = '0;
    tmr_cnt       = '0;
    tmr_reload    = '0;
    tmr_ctrl      = '0;
    tmr_clk_lvl   = 1'b0;
    ser_data      = '0;
    ser_ctrl      = '0;
    ser_bits_left = '0;

    // directed: unmapped reads and writes, read masks, undefined kind
    add_item(KIND_READ, ADDR_HOLE_LO, 8'h00);
    add_item(KIND_READ, ADDR_HOLE_HI, 8'h00);
    add_item(KIND_READ, ADDR_SCTRL, 8'h00);
    add_item(KIND_READ, ADDR_TCTRL, 8'h00);
    add_item(KIND_WRITE, ADDR_HOLE_LO, 8'hff);
    add_item(KIND_WRITE, ADDR_HOLE_HI, 8'hff);
    add_item(KIND_UNDEF, ADDR_SDATA, 8'hff);
    add_item(KIND_READ, ADDR_SDATA, 8'h00);
    add_item(KIND_WRITE, ADDR_SDATA, 8'hff);
    add_item(KIND_READ, ADDR_SDATA, 8'h00);
    add_item(KIND_WRITE, ADDR_SDATA, 8'h00);
    // serial control with only the start bit does not start a transfer
    add_item(KIND_WRITE, ADDR_SCTRL, 8'h80);
    add_item(KIND_READ, ADDR_SCTRL, 8'h00);
    // all bits set keeps start and clock select, starts a transfer
    add_item(KIND_WRITE, ADDR_SCTRL, 8'hff);
    // divider write clears it whatever the byte, serial shifts next cycle
    add_item(KIND_WRITE, ADDR_DIVIDER, 8'hab);
    add_item(KIND_READ, ADDR_SDATA, 8'h00);
    // fast timer close to wrap
    add_item(KIND_WRITE, ADDR_TRELOAD, 8'hfe);
    add_item(KIND_WRITE, ADDR_TCOUNT, 8'hff);
    add_item(KIND_WRITE, ADDR_TCTRL, {5'h1f, TSEL_BIT1});
    add_item(KIND_IDLE, ADDR_SDATA, 8'h00);
    add_item(KIND_READ, ADDR_TCOUNT, 8'h00);
    add_item(KIND_WRITE, ADDR_TCTRL, {5'h00, TSEL_BIT5});
    // disabling may clock the timer once
    add_item(KIND_WRITE, ADDR_TCTRL, {5'h00, TSEL_OFF});
    add_item(KIND_READ, ADDR_TRELOAD, 8'h00);
    add_item(KIND_WRITE, ADDR_TCTRL, {5'h00, TSEL_BIT7});

    // idle stretch: serial transfer running, slow timer
    add_item(KIND_WRITE, ADDR_SCTRL, SCTRL_GO);
    for (int i = 0; i < SOAK_ITEMS; i++) begin
      if ($urandom_range(0, 31) == 0)
        add_item(KIND_READ, 3'($urandom_range(0, 7)), 8'($urandom));
      else
        add_item($urandom_range(0, 7) == 0 ? KIND_UNDEF : KIND_IDLE,
                 3'($urandom_range(0, 7)), 8'($urandom));
    end

    // random: timer set-ups, serial transfers, and noise
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        add_item(KIND_WRITE, ADDR_TRELOAD,
                 $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(240, 255)));
        add_item(KIND_WRITE, ADDR_TCOUNT, 8'($urandom_range(200, 255)));
        add_item(KIND_WRITE, ADDR_TCTRL, 8'($urandom));
        len = $urandom_range(4, 40);
        n_random += 3 + len;
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 5))
            0:       add_item(KIND_READ, ADDR_TCOUNT, 8'($urandom));
            1:       add_item(KIND_READ, ADDR_DIVIDER, 8'($urandom));
            2:       add_item(KIND_WRITE, ADDR_DIVIDER, 8'($urandom));
            default: add_item(KIND_IDLE, 3'($urandom_range(0, 7)), 8'($urandom));
          endcase
        end
      end else if (pick < 8) begin
        add_item(KIND_WRITE, ADDR_SDATA, 8'($urandom));
        add_item(KIND_WRITE, ADDR_SCTRL, 8'($urandom) | SCTRL_GO);
        len = $urandom_range(20, 90);
        n_random += 2 + len;
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 11))
            0, 1, 2: add_item(KIND_WRITE, ADDR_DIVIDER, 8'($urandom));
            3:       add_item(KIND_READ, ADDR_SDATA, 8'($urandom));
            4:       add_item(KIND_READ, ADDR_SCTRL, 8'($urandom));
            5:       begin
              // occasionally break the transfer
              if ($urandom_range(0, 5) == 0)
                add_item(KIND_WRITE, ADDR_SCTRL, 8'($urandom));
              else
                add_item(KIND_READ, ADDR_TCTRL, 8'($urandom));
            end
            default: add_item(KIND_IDLE, 3'($urandom_range(0, 7)), 8'($urandom));
          endcase
        end
      end else begin
        len = $urandom_range(1, 10);
        n_random += len;
        for (int i = 0; i < len; i++)
          add_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 8'($urandom));
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything sent and every result back
    do @(negedge clk);
    while (pending_q.size() != 0 || in_tvalid || expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
